// ----- src/gmc_pkg.sv -----
// ----------------------------------------------------------------------------
// gmc_pkg
// Stage types, constants and small tables of the calendar / day number /
// epoch seconds converter.
// ----------------------------------------------------------------------------
package gmc_pkg;

  localparam logic [1:0] OP_CALENDAR   = 2'd0;
  localparam logic [1:0] OP_DAY_NUMBER = 2'd1;

  localparam int STAGES = 13;

  localparam logic [16:0] SEC_PER_DAY = 17'd86400;

  // biased day count: 400-year cycles added so that every day number is positive
  localparam logic [23:0] DAY_BIAS   = 24'd4769597;
  localparam logic [23:0] CAL_BIAS   = 24'd3944618;
  localparam logic [39:0] EPOCH_BIAS = 40'd416546582400;
  localparam logic [14:0] YEAR_BIAS  = 15'd400;
  localparam logic [17:0] YEAR_SHIFT = 18'd11200;

  // reciprocals for constant division
  localparam logic [13:0] MAG25     = 14'd10486;      // x / 25,     shift 18
  localparam logic [17:0] MAG675H   = 18'd198842;     // x / 675,    shift 27
  localparam logic [26:0] MAG675L   = 27'd101806633;  // x / 675,    shift 36
  localparam logic [24:0] MAG400Y   = 25'd30103606;   // x / 146097, shift 42
  localparam logic [16:0] MAG1461   = 17'd91868;      // x / 1461,   shift 27
  localparam logic [17:0] MAG60     = 18'd139811;     // x / 60,     shift 23
  localparam logic [11:0] MAG60H    = 12'd2185;       // x / 60,     shift 17
  localparam logic [23:0] MONTH_MUL = 24'd34270;      // (5x + 308) / 153
  localparam logic [23:0] MONTH_ADD = 24'd2111032;

  typedef struct packed {
    logic [1:0]  op;
    logic [14:0] cal_yb;
    logic [8:0]  cal_dm;
    logic [16:0] cal_ts;
    logic [23:0] mjd_jd;
    logic [16:0] mjd_sod;
    logic [39:0] ep_u;
  } s1_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [22:0] p365;
    logic [12:0] q4;
    logic [8:0]  q100;
    logic [8:0]  q400;
    logic [8:0]  cal_dm;
    logic [16:0] cal_ts;
    logic [23:0] mjd_jd;
    logic [16:0] mjd_sod;
    logic [7:0]  q1;
    logic [39:0] ep_u;
  } s2_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] cal_jd;
    logic [16:0] cal_sod;
    logic [23:0] mjd_jd;
    logic [16:0] mjd_sod;
    logic [7:0]  q1;
    logic [25:0] x2;
    logic [6:0]  ep_lo;
  } s3_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] cal_jd;
    logic [16:0] cal_sod;
    logic [23:0] mjd_jd;
    logic [16:0] mjd_sod;
    logic [7:0]  q1;
    logic [15:0] q0;
    logic [25:0] x2;
    logic [6:0]  ep_lo;
  } s4_t;

  typedef struct packed {
    logic [23:0] jd;
    logic [16:0] sod;
  } s5_t;

  typedef struct packed {
    logic [23:0] jd;
    logic [6:0]  g;
    logic [16:0] sod;
    logic [10:0] qm;
    logic [40:0] eprod;
    logic [22:0] dn;
  } s6_t;

  typedef struct packed {
    logic [6:0]  g;
    logic [17:0] dg;
    logic [10:0] qm;
    logic [4:0]  qh;
    logic [5:0]  sec;
    logic [38:0] epoch;
    logic [22:0] dn;
    logic [16:0] sod;
  } s7_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
    logic [22:0] dn;
    logic [16:0] sod;
    logic [38:0] epoch;
  } tail_t;

  typedef struct packed {
    logic [6:0]  g;
    logic [1:0]  c;
    logic [15:0] dc;
    tail_t       tail;
  } s8_t;

  typedef struct packed {
    logic [6:0]  g;
    logic [1:0]  c;
    logic [15:0] dc;
    logic [4:0]  b;
    tail_t       tail;
  } s9_t;

  typedef struct packed {
    logic [10:0] db;
    logic [16:0] ypart;
    tail_t       tail;
  } s10_t;

  typedef struct packed {
    logic [8:0]  da;
    logic [16:0] ysum;
    tail_t       tail;
  } s11_t;

  typedef struct packed {
    logic [3:0]  m;
    logic [8:0]  da;
    logic [16:0] ysum;
    tail_t       tail;
  } s12_t;

  // days from march 1 to the first of shifted month m
  function automatic logic [8:0] days_before(input logic [3:0] m);
    case (m)
      4'd0:    days_before = 9'd0;
      4'd1:    days_before = 9'd31;
      4'd2:    days_before = 9'd61;
      4'd3:    days_before = 9'd92;
      4'd4:    days_before = 9'd122;
      4'd5:    days_before = 9'd153;
      4'd6:    days_before = 9'd184;
      4'd7:    days_before = 9'd214;
      4'd8:    days_before = 9'd245;
      4'd9:    days_before = 9'd275;
      4'd10:   days_before = 9'd306;
      4'd11:   days_before = 9'd337;
      default: days_before = 9'd0;
    endcase
  endfunction

  // century within a 400-year cycle, last day stays in the fourth century
  function automatic logic [1:0] century_of(input logic [17:0] dg);
    if (dg >= 18'd109572) begin
      century_of = 2'd3;
    end else if (dg >= 18'd73048) begin
      century_of = 2'd2;
    end else if (dg >= 18'd36524) begin
      century_of = 2'd1;
    end else begin
      century_of = 2'd0;
    end
  endfunction

  // year within a 4-year cycle, leap day stays in the fourth year
  function automatic logic [1:0] year_of(input logic [10:0] db);
    if (db >= 11'd1095) begin
      year_of = 2'd3;
    end else if (db >= 11'd730) begin
      year_of = 2'd2;
    end else if (db >= 11'd365) begin
      year_of = 2'd1;
    end else begin
      year_of = 2'd0;
    end
  endfunction

endpackage

// ----- src/gregorian_mjd_converter.sv -----
// ----------------------------------------------------------------------------
// gregorian_mjd_converter
// Converts a time point given as calendar date and time, modified julian day
// and second of day, or seconds since J2000 into all three forms.
// ----------------------------------------------------------------------------
// One beat enters per clock and one result leaves per cycle. The pipeline
// depth is set by the chain of constant-divisor stages: the split of epoch
// seconds into day and second (two base-65536 division digits by 675) and
// the 400/100/4/1-year breakdown of the day count. busy is high only in
// reset. Each result shows on the output ports for the single cycle in
// which done is high; the receiver cannot hold it off and must take it
// then. Years outside 1 to 9999 set out_of_range and keep the low bits.
module gregorian_mjd_converter (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [13:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  input  logic signed [22:0] day_number,
  input  logic [16:0]        second_of_day,
  input  logic signed [38:0] epoch_seconds,
  output logic               done,
  output logic [13:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second,
  output logic signed [22:0] out_day_number,
  output logic [16:0]        out_second_of_day,
  output logic signed [38:0] out_epoch_seconds,
  output logic               out_of_range
);
  import gmc_pkg::*;

  logic              in_fire;
  logic [STAGES-1:0] vld;

  s1_t  st1, st1_next;
  s2_t  st2, st2_next;
  s3_t  st3, st3_next;
  s4_t  st4, st4_next;
  s5_t  st5, st5_next;
  s6_t  st6, st6_next;
  s7_t  st7, st7_next;
  s8_t  st8, st8_next;
  s9_t  st9, st9_next;
  s10_t st10, st10_next;
  s11_t st11, st11_next;
  s12_t st12, st12_next;

  logic [3:0]  cal_m;
  logic        mjd_carry;
  logic [26:0] prod100, prod400;
  logic [34:0] prod1;
  logic [23:0] cal_pre;
  logic        cal_tc;
  logic [16:0] rem1;
  logic [52:0] prod0;
  logic [25:0] rem0;
  logic [48:0] prod_g;
  logic [34:0] prod_qm;
  logic [22:0] prod_qh;
  logic [23:0] dgw;
  logic [16:0] secw;
  logic [40:0] epw;
  logic [17:0] dcw;
  logic [10:0] minw;
  logic [32:0] prod_b;
  logic [15:0] dbw;
  logic [1:0]  yr_a;
  logic [10:0] daw;
  logic [23:0] prod_m;
  logic        year_carry;
  logic [17:0] yyw;
  logic [8:0]  dayw;

  assign busy    = rst;
  assign in_fire = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], in_fire};
    end
  end

  assign done = vld[STAGES-1];

  // input beat: month shift, time of day, day number carry, epoch bias
  always_comb begin
    if (month <= 4'd2) begin
      cal_m           = month + 4'd9;
      st1_next.cal_yb = 15'(year) + YEAR_BIAS - 15'd1;
    end else if (month == 4'd15) begin
      cal_m           = 4'd0;
      st1_next.cal_yb = 15'(year) + YEAR_BIAS + 15'd1;
    end else begin
      cal_m           = month - 4'd3;
      st1_next.cal_yb = 15'(year) + YEAR_BIAS;
    end
    st1_next.op      = operation;
    st1_next.cal_dm  = 9'(day) + days_before(cal_m);
    st1_next.cal_ts  = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
    mjd_carry        = second_of_day >= SEC_PER_DAY;
    st1_next.mjd_sod = mjd_carry ? second_of_day - SEC_PER_DAY : second_of_day;
    st1_next.mjd_jd  = {day_number[22], day_number} + DAY_BIAS + 24'(mjd_carry);
    st1_next.ep_u    = {epoch_seconds[38], epoch_seconds} + EPOCH_BIAS;
  end

  // leap year terms, high digit of the epoch day split
  always_comb begin
    prod100          = 27'(st1.cal_yb[14:2]) * 27'(MAG25);
    prod400          = 27'(st1.cal_yb[14:4]) * 27'(MAG25);
    prod1            = 35'(st1.ep_u[39:23]) * 35'(MAG675H);
    st2_next.op      = st1.op;
    st2_next.p365    = 23'(st1.cal_yb) * 23'd365;
    st2_next.q4      = st1.cal_yb[14:2];
    st2_next.q100    = prod100[26:18];
    st2_next.q400    = prod400[26:18];
    st2_next.cal_dm  = st1.cal_dm;
    st2_next.cal_ts  = st1.cal_ts;
    st2_next.mjd_jd  = st1.mjd_jd;
    st2_next.mjd_sod = st1.mjd_sod;
    st2_next.q1      = prod1[34:27];
    st2_next.ep_u    = st1.ep_u;
  end

  always_comb begin
    cal_pre = 24'(st2.p365) + 24'(st2.q4) - 24'(st2.q100) + 24'(st2.q400)
            + 24'(st2.cal_dm) + CAL_BIAS;
    cal_tc  = st2.cal_ts >= SEC_PER_DAY;
    rem1    = st2.ep_u[39:23] - 17'(st2.q1) * 17'd675;
    st3_next.op      = st2.op;
    st3_next.cal_jd  = cal_pre + 24'(cal_tc);
    st3_next.cal_sod = cal_tc ? st2.cal_ts - SEC_PER_DAY : st2.cal_ts;
    st3_next.mjd_jd  = st2.mjd_jd;
    st3_next.mjd_sod = st2.mjd_sod;
    st3_next.q1      = st2.q1;
    st3_next.x2      = {rem1[9:0], st2.ep_u[22:7]};
    st3_next.ep_lo   = st2.ep_u[6:0];
  end

  always_comb begin
    prod0            = 53'(st3.x2) * 53'(MAG675L);
    st4_next.op      = st3.op;
    st4_next.cal_jd  = st3.cal_jd;
    st4_next.cal_sod = st3.cal_sod;
    st4_next.mjd_jd  = st3.mjd_jd;
    st4_next.mjd_sod = st3.mjd_sod;
    st4_next.q1      = st3.q1;
    st4_next.q0      = prod0[51:36];
    st4_next.x2      = st3.x2;
    st4_next.ep_lo   = st3.ep_lo;
  end

  // select the source form
  always_comb begin
    rem0 = st4.x2 - 26'(st4.q0) * 26'd675;
    case (st4.op)
      OP_CALENDAR: begin
        st5_next.jd  = st4.cal_jd;
        st5_next.sod = st4.cal_sod;
      end
      OP_DAY_NUMBER: begin
        st5_next.jd  = st4.mjd_jd;
        st5_next.sod = st4.mjd_sod;
      end
      default: begin
        st5_next.jd  = {st4.q1, st4.q0};
        st5_next.sod = {rem0[9:0], st4.ep_lo};
      end
    endcase
  end

  always_comb begin
    prod_g         = 49'(st5.jd) * 49'(MAG400Y);
    prod_qm        = 35'(st5.sod) * 35'(MAG60);
    st6_next.jd    = st5.jd;
    st6_next.g     = prod_g[48:42];
    st6_next.sod   = st5.sod;
    st6_next.qm    = prod_qm[33:23];
    st6_next.eprod = 41'(st5.jd) * 41'(SEC_PER_DAY);
    st6_next.dn    = 23'(st5.jd - DAY_BIAS);
  end

  always_comb begin
    dgw     = st6.jd - 24'(st6.g) * 24'd146097;
    secw    = st6.sod - 17'(st6.qm) * 17'd60;
    prod_qh = 23'(st6.qm) * 23'(MAG60H);
    epw     = st6.eprod + 41'(st6.sod) - 41'(EPOCH_BIAS);
    st7_next.g     = st6.g;
    st7_next.dg    = dgw[17:0];
    st7_next.qm    = st6.qm;
    st7_next.qh    = prod_qh[21:17];
    st7_next.sec   = secw[5:0];
    st7_next.epoch = epw[38:0];
    st7_next.dn    = st6.dn;
    st7_next.sod   = st6.sod;
  end

  always_comb begin
    st8_next.c           = century_of(st7.dg);
    dcw                  = st7.dg - 18'(st8_next.c) * 18'd36524;
    minw                 = st7.qm - 11'(st7.qh) * 11'd60;
    st8_next.g           = st7.g;
    st8_next.dc          = dcw[15:0];
    st8_next.tail.hour   = st7.qh;
    st8_next.tail.minute = minw[5:0];
    st8_next.tail.sec    = st7.sec;
    st8_next.tail.dn     = st7.dn;
    st8_next.tail.sod    = st7.sod;
    st8_next.tail.epoch  = st7.epoch;
  end

  always_comb begin
    prod_b        = 33'(st8.dc) * 33'(MAG1461);
    st9_next.g    = st8.g;
    st9_next.c    = st8.c;
    st9_next.dc   = st8.dc;
    st9_next.b    = prod_b[31:27];
    st9_next.tail = st8.tail;
  end

  always_comb begin
    dbw              = st9.dc - 16'(st9.b) * 16'd1461;
    st10_next.db     = dbw[10:0];
    st10_next.ypart  = 17'(st9.g) * 17'd400 + 17'(st9.c) * 17'd100 + 17'(st9.b) * 17'd4;
    st10_next.tail   = st9.tail;
  end

  always_comb begin
    yr_a           = year_of(st10.db);
    daw            = st10.db - 11'(yr_a) * 11'd365;
    st11_next.da   = daw[8:0];
    st11_next.ysum = st10.ypart + 17'(yr_a);
    st11_next.tail = st10.tail;
  end

  always_comb begin
    prod_m         = 24'(st11.da) * MONTH_MUL + MONTH_ADD;
    st12_next.m    = prod_m[23:20] - 4'd2;
    st12_next.da   = st11.da;
    st12_next.ysum = st11.ysum;
    st12_next.tail = st11.tail;
  end

  always_comb begin
    year_carry = st12.m >= 4'd10;
    yyw        = 18'(st12.ysum) - YEAR_SHIFT + 18'(year_carry);
    dayw       = st12.da - days_before(st12.m) + 9'd1;
  end

  always_ff @(posedge clk) begin
    st1  <= st1_next;
    st2  <= st2_next;
    st3  <= st3_next;
    st4  <= st4_next;
    st5  <= st5_next;
    st6  <= st6_next;
    st7  <= st7_next;
    st8  <= st8_next;
    st9  <= st9_next;
    st10 <= st10_next;
    st11 <= st11_next;
    st12 <= st12_next;
    out_year          <= yyw[13:0];
    out_month         <= year_carry ? st12.m - 4'd9 : st12.m + 4'd3;
    out_day           <= dayw[4:0];
    out_hour          <= st12.tail.hour;
    out_minute        <= st12.tail.minute;
    out_second        <= st12.tail.sec;
    out_day_number    <= st12.tail.dn;
    out_second_of_day <= st12.tail.sod;
    out_epoch_seconds <= st12.tail.epoch;
    out_of_range      <= ($signed(yyw) < 18'sd1) || ($signed(yyw) > 18'sd9999);
  end

endmodule
